// ===== hdl/sorted_mac_key_set_assert.svh =====
// ----------------------------------------------------------------------------
// sorted_mac_key_set_assert.svh
// Assertion macros for the sorted MAC key set. They compile away under SYNTH.
// ----------------------------------------------------------------------------
`ifndef SORTED_MAC_KEY_SET_ASSERT_SVH
`define SORTED_MAC_KEY_SET_ASSERT_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define SMKS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("sorted_mac_key_set: invariant violated");

// Antecedent in one cycle implies consequent in the next cycle.
`define SMKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted_mac_key_set: sequence check failed");

`else

`define SMKS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SMKS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/smks_pkg.sv =====
// ----------------------------------------------------------------------------
// smks_pkg
// Shared types and codes of the sorted MAC key set.
// ----------------------------------------------------------------------------
package smks_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 48;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 5;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic             func;
		logic [KEY_W-1:0] mac_key;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  entry_count;
	} rsp_t;

	// Per-cycle commands broadcast to every cell of the chain.
	typedef struct packed {
		logic capture;  // latch the compare flags against the incoming key
		logic ins_en;   // open a gap at the sorted position and write the key
		logic del_en;   // close the gap at the matching entry
	} cell_ctrl_t;

endpackage

// ===== hdl/smks_stream_if.sv =====
// ----------------------------------------------------------------------------
// smks_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface smks_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/smks_cell.sv =====
// ----------------------------------------------------------------------------
// smks_cell
// One slot of the sorted key chain: holds a key, compares it and shifts.
// ----------------------------------------------------------------------------
module smks_cell
	import smks_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [KEY_W-1:0] cmp_key,   // key of the beat being accepted
	input  logic [KEY_W-1:0] new_key,   // key held for the update cycle
	input  logic [CNT_W-1:0] count,
	input  logic             prev_lt,   // left neighbor holds a smaller key
	input  logic [KEY_W-1:0] prev_key,
	input  logic [KEY_W-1:0] next_key,
	output logic             lt_s1,
	output logic             eq_s1,
	output logic [KEY_W-1:0] key_q
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic occupied;

	assign occupied = (IDX_C < count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_s1 <= 1'b0;
			eq_s1 <= 1'b0;
		end else if (ctrl.capture) begin
			lt_s1 <= occupied && (key_q < cmp_key);
			eq_s1 <= occupied && (key_q == cmp_key);
		end
	end

	// Entries below the sorted position keep their key; the first one at or
	// above it takes the new key, the rest take their left neighbor's key.
	// On removal every entry at or above the match takes its right neighbor.
	always_ff @(posedge clk) begin
		if (ctrl.ins_en && !lt_s1) begin
			key_q <= prev_lt ? new_key : prev_key;
		end else if (ctrl.del_en && !lt_s1) begin
			key_q <= next_key;
		end
	end

endmodule

// ===== hdl/sorted_mac_key_set.sv =====
// ----------------------------------------------------------------------------
// sorted_mac_key_set
// Operation: a request beat is taken only while no earlier request is being
// committed. Its beat latches the compare flags in the cell chain; the
// shift-and-commit step then updates the chain and registers the response,
// and it stretches while an earlier response waits in the output register.
// Reset: asynchronous, clears the entry count and handshake state; key cells
// are not cleared, since only entries below the count are ever compared.
// ----------------------------------------------------------------------------
`include "sorted_mac_key_set_assert.svh"

module sorted_mac_key_set
	import smks_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	smks_stream_if.sink   req,
	smks_stream_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	// Request held for the commit cycle.
	logic             busy_q;
	logic             func_s1;
	logic [KEY_W-1:0] key_s1;

	// Number of valid keys; cells below this index hold the sorted set.
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;

	// Output register, so a new request can be taken while a response waits.
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             commit;
	logic             hit;
	logic [STATUS_W-1:0] status_next;
	cell_ctrl_t       ctrl;

	logic             lt_w  [CAPACITY];
	logic [CAPACITY-1:0] eq_w;
	logic [KEY_W-1:0] key_w [CAPACITY];

	// A request is taken whenever no earlier request is still being committed.
	assign req.ready = !busy_q;
	assign accept    = req.valid && req.ready;

	// The commit cycle waits until the output register is free or drains now.
	assign commit    = busy_q && (!rsp_valid_q || rsp.ready);

	// Any occupied cell matching the key means the key is present.
	assign hit = |eq_w;

	always_comb begin
		status_next  = ST_DONE;
		count_next   = count_q;
		ctrl.capture = accept;
		ctrl.ins_en  = 1'b0;
		ctrl.del_en  = 1'b0;
		unique case (func_s1)
			FUNC_INSERT: begin
				// The duplicate check wins over the full check.
				if (hit) begin
					status_next = ST_DUPLICATE;
				end else if (count_q >= CAP_C) begin
					status_next = ST_FULL;
				end else begin
					ctrl.ins_en = commit;
					count_next  = count_q + CNT_W'(1);
				end
			end
			FUNC_REMOVE: begin
				if (!hit) begin
					status_next = ST_NOT_FOUND;
				end else begin
					ctrl.del_en = commit;
					count_next  = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_next = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= req.data.func;
			key_s1  <= req.data.mac_key;
		end
		if (commit) begin
			rsp_q.status      <= status_next;
			// Only the low bits of the count fit the field for large tables.
			rsp_q.entry_count <= COUNT_W'(count_next);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// The chain of cells. The first cell sees an always-smaller left neighbor
	// so it takes the new key when the key sorts to the front; the last cell
	// reloads itself on removal, which only touches the slot leaving the set.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic             prev_lt;
		logic [KEY_W-1:0] prev_key;
		logic [KEY_W-1:0] next_key;

		if (i == 0) begin : g_first
			assign prev_lt  = 1'b1;
			assign prev_key = key_s1;
		end else begin : g_mid
			assign prev_lt  = lt_w[i-1];
			assign prev_key = key_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_key = key_w[i];
		end else begin : g_inner
			assign next_key = key_w[i+1];
		end

		smks_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.cmp_key  (req.data.mac_key),
			.new_key  (key_s1),
			.count    (count_q),
			.prev_lt  (prev_lt),
			.prev_key (prev_key),
			.next_key (next_key),
			.lt_s1    (lt_w[i]),
			.eq_s1    (eq_w[i]),
			.key_q    (key_w[i])
		);
	end

	// The count never passes the table size.
	`SMKS_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CAP_C)
	// A sorted set holds each key once, so at most one cell can match.
	`SMKS_ASSERT_ALWAYS(a_single_match, clk, arst_n, !busy_q || $onehot0(eq_w))
	// A committed request always leaves a response in the output register.
	`SMKS_ASSERT_NEXT(a_commit_rsp, clk, arst_n, commit, rsp_valid_q)
	// A successful insert grows the table by exactly one entry.
	`SMKS_ASSERT_NEXT(a_insert_grows, clk, arst_n, ctrl.ins_en, count_q == $past(count_q) + CNT_W'(1))

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted MAC key set. A queue of insert and remove
// requests (a directed opening, then random traffic drawn mostly from a small
// key pool) is streamed into the block. A sorted shadow table predicts the
// status and entry count of every response, and each response is compared
// with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import smks_pkg::*;

	localparam int CAPACITY       = CAPACITY_DEF;
	localparam int RANDOM_ITEMS   = 430;
	localparam int POOL_SIZE      = 24;
	localparam int IDLE_PERCENT   = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	// Requests accepted inside this window are never delayed by either side,
	// so the block also sees a long run of back-to-back traffic.
	localparam int QUIET_FIRST = 200;
	localparam int QUIET_LAST  = 300;

	logic clk = 1'b0;
	logic arst_n;

	smks_stream_if #(.payload_t(req_t)) req_ch ();
	smks_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	sorted_mac_key_set #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #2 clk = ~clk;

	// Shadow copy of the key table, kept in ascending order.
	logic [KEY_W-1:0] mac_table[$];
	req_t             pending_requests[$];
	rsp_t             expected_results[$];
	logic [KEY_W-1:0] key_pool[POOL_SIZE];

	int failures;
	int beats_accepted;
	int idle_free_cycles;
	int insert_count;
	int remove_count;
	int peak_entries;
	int status_seen[4];

	// True while neither side may stall.
	wire quiet = beats_accepted >= QUIET_FIRST && beats_accepted < QUIET_LAST;

	function automatic logic [KEY_W-1:0] random_key();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[KEY_W-1:0];
	endfunction

	// Applies one request to the shadow table and returns the response it
	// must produce. The duplicate check comes before the full check, so a
	// key that is already present reports a duplicate even in a full table.
	function automatic rsp_t apply_request(req_t r);
		int   pos;
		bit   hit;
		rsp_t res;
		pos = 0;
		while (pos < mac_table.size() && mac_table[pos] < r.mac_key)
			pos++;
		hit = pos < mac_table.size() && mac_table[pos] == r.mac_key;
		res.status = ST_DONE;
		if (r.func == FUNC_INSERT) begin
			insert_count++;
			if (hit) begin
				res.status = ST_DUPLICATE;
			end else if (mac_table.size() >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				mac_table.insert(pos, r.mac_key);
			end
		end else begin
			remove_count++;
			if (!hit) begin
				res.status = ST_NOT_FOUND;
			end else begin
				mac_table.delete(pos);
			end
		end
		if (mac_table.size() > peak_entries)
			peak_entries = mac_table.size();
		res.entry_count = COUNT_W'(mac_table.size());
		return res;
	endfunction

	function automatic void queue_request(logic func, logic [KEY_W-1:0] key);
		req_t r;
		r.func    = func;
		r.mac_key = key;
		pending_requests.push_back(r);
	endfunction

	// Request driver. A new beat is offered only when the previous one has
	// been taken (or none is pending); the prediction is made at the edge at
	// which the block accepts the beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_results.push_back(apply_request(req_ch.data));
				beats_accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_requests.size() > 0 &&
				    (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
					req_ch.valid <= 1'b1;
					req_ch.data  <= pending_requests.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response sink: ready drops now and then so that stalls land on every
	// phase of the block's compare and commit operation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= quiet || $urandom_range(99) >= IDLE_PERCENT;
		end
	end

	// Response monitor: every accepted beat is checked against the oldest
	// prediction, field by field.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("response beat with no request outstanding: status %0d count %0d",
				       rsp_ch.data.status, rsp_ch.data.entry_count);
				failures++;
			end else begin
				rsp_t exp_rsp;
				exp_rsp = expected_results.pop_front();
				status_seen[exp_rsp.status]++;
				if (rsp_ch.data.status !== exp_rsp.status) begin
					$error("status: expected %0d, actual %0d",
					       exp_rsp.status, rsp_ch.data.status);
					failures++;
				end
				if (rsp_ch.data.entry_count !== exp_rsp.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
					       exp_rsp.entry_count, rsp_ch.data.entry_count);
					failures++;
				end
			end
		end
	end

	// Watchdog: too many cycles without any beat on either channel ends the
	// run as a failure.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_free_cycles <= 0;
			end else if (idle_free_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("watchdog expired after %0d cycles without a beat",
				         WATCHDOG_LIMIT);
				$display("simulation failed");
				$finish;
			end else begin
				idle_free_cycles <= idle_free_cycles + 1;
			end
		end
	end

	initial begin
		int   phase_insert_pct;
		logic func;
		logic [KEY_W-1:0] key;

		// Known values on every input from time zero.
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		failures         = 0;
		beats_accepted   = 0;
		idle_free_cycles = 0;
		insert_count     = 0;
		remove_count     = 0;
		peak_entries     = 0;
		status_seen      = '{default: 0};

		// Directed opening: empty table, extreme keys, a full table and
		// removal at the first, a middle and the last position.
		queue_request(FUNC_REMOVE, '0);                 // remove from an empty table
		queue_request(FUNC_INSERT, '1);
		queue_request(FUNC_INSERT, '0);
		queue_request(FUNC_INSERT, '1);                 // duplicate
		queue_request(FUNC_REMOVE, 48'h8000_0000_0000); // absent key
		queue_request(FUNC_INSERT, 48'h0000_0000_0001);
		queue_request(FUNC_INSERT, 48'hFFFF_FFFF_FFFE);
		queue_request(FUNC_INSERT, 48'h0100_0000_0000); // first byte dominates
		queue_request(FUNC_INSERT, 48'h00FF_FFFF_FFFF);
		for (int i = 1; i <= CAPACITY - 6; i++)
			queue_request(FUNC_INSERT, {8'(i * 23), 40'h55_AA33_CC0F});
		queue_request(FUNC_INSERT, 48'h7777_7777_7777); // table full
		queue_request(FUNC_INSERT, '0);                 // duplicate while full
		queue_request(FUNC_REMOVE, 48'h0100_0000_0000);
		queue_request(FUNC_REMOVE, '0);
		queue_request(FUNC_REMOVE, '1);

		// Key pool: larger than the table so that it fills up, with close
		// neighbors and byte-boundary keys to stress the ordering compare.
		for (int i = 0; i < 16; i++)
			key_pool[i] = random_key();
		for (int i = 16; i < 20; i++)
			key_pool[i] = key_pool[i - 16] + 1'b1;
		key_pool[20] = '0;
		key_pool[21] = '1;
		key_pool[22] = 48'h0100_0000_0000;
		key_pool[23] = 48'h00FF_FFFF_FFFF;

		// Random traffic in phases that lean toward inserts, toward a
		// balance, and toward removes, so the table swings between full
		// and empty. A few keys are fresh random values.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ((n / 40) % 3)
				0: begin
					phase_insert_pct = 80;
				end
				1: begin
					phase_insert_pct = 50;
				end
				default: begin
					phase_insert_pct = 20;
				end
			endcase
			func = ($urandom_range(99) < phase_insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
			if ($urandom_range(99) < 8)
				key = random_key();
			else
				key = key_pool[$urandom_range(POOL_SIZE - 1)];
			queue_request(func, key);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every request taken and every response seen, then a settling
		// wait to catch a stray extra beat.
		while (pending_requests.size() > 0 || req_ch.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d inserts and %0d removes; the table held up to %0d keys.",
		         insert_count, remove_count, peak_entries);
		$display("Outcomes: %0d done, %0d duplicate, %0d full, %0d not found.",
		         status_seen[ST_DONE], status_seen[ST_DUPLICATE],
		         status_seen[ST_FULL], status_seen[ST_NOT_FOUND]);
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
